// ===== rtl/lfsr128_pkg.sv =====
// Shared constants and types for the scrambled 128-bit LFSR random source.
// Used by lfsr128_mul and lfsr128_scrambled_rng_unit; depends on nothing.
package lfsr128_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = 32;
  localparam int CNT_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] WARMUP_STEPS = 16'd6528;
  localparam logic [CNT_W-1:0] BITS_WIDE = 16'd64;
  localparam logic [CNT_W-1:0] BITS_NARROW = 16'd32;

  localparam logic [WORD_W-1:0] SCRAMBLE_MULT = 64'h2545F4914F6CDD1D;
  localparam logic [WORD_W-1:0] FALLBACK_RESET = 64'd1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NARROW_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_SEED = 2'd1;

  // Command codes carried on in_tuser.
  localparam logic CMD_GENERATE = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

endpackage

// ===== rtl/lfsr128_mul.sv =====
// Iterative 64-bit by constant multiplier, product kept modulo 2^64.
// One shared 32x32 multiplier runs three passes; uses lfsr128_pkg.
module lfsr128_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  lfsr128_pkg::word_t  operand,
  output logic                done,
  output lfsr128_pkg::word_t  product
);
  import lfsr128_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LO_LO = 2'd1;
  localparam logic [1:0] PH_HI_LO = 2'd2;
  localparam logic [1:0] PH_LO_HI = 2'd3;

  logic [1:0]        phase_r, phase_nxt;
  logic              done_r, done_nxt;
  word_t             op_r, op_nxt;
  word_t             acc_r, acc_nxt;
  logic [HALF_W-1:0] mul_a, mul_b;
  word_t             mul_p;

  // Shared 32x32 multiplier; only the operand selection changes per pass.
  assign mul_p = word_t'(mul_a) * word_t'(mul_b);

  always_comb begin
    mul_a = op_r[HALF_W-1:0];
    mul_b = SCRAMBLE_MULT[HALF_W-1:0];
    unique case (phase_r)
      PH_HI_LO: mul_a = op_r[WORD_W-1:HALF_W];
      PH_LO_HI: mul_b = SCRAMBLE_MULT[WORD_W-1:HALF_W];
      default: ;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    done_nxt = 1'b0;
    op_nxt = op_r;
    acc_nxt = acc_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (start) begin
          op_nxt = operand;
          phase_nxt = PH_LO_LO;
        end
      end
      PH_LO_LO: begin
        acc_nxt = mul_p;
        phase_nxt = PH_HI_LO;
      end
      PH_HI_LO: begin
        // Cross terms only reach the upper half of a 64-bit product.
        acc_nxt[WORD_W-1:HALF_W] = acc_r[WORD_W-1:HALF_W] + mul_p[HALF_W-1:0];
        phase_nxt = PH_LO_HI;
      end
      PH_LO_HI: begin
        acc_nxt[WORD_W-1:HALF_W] = acc_r[WORD_W-1:HALF_W] + mul_p[HALF_W-1:0];
        phase_nxt = PH_IDLE;
        done_nxt = 1'b1;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r <= done_nxt;
    end
    op_r <= op_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign product = acc_r;

endmodule

// ===== rtl/lfsr128_scrambled_rng_unit.sv =====
// Scrambled 128-bit Fibonacci LFSR random source, top level.
// Uses lfsr128_pkg and lfsr128_mul.
//
// Usage:
// - Input beats on in_*: in_tuser selects the command (generate or reseed),
//   in_tdata carries the seed. A generate beat yields one output beat on
//   out_*; a reseed beat yields none.
// - Configuration writes on cfg_* (index 0 narrow_mode, 1 fallback_seed)
//   are always taken; other indexes are dropped. Write only while idle.
// - The LFSR advances one bit per cycle while warming up or collecting
//   bits. A generate collects 64 bits in wide mode or 32 in narrow mode,
//   starts the shared 32x32 multiplier, waits until its product is taken
//   and loads the output register, which raises out_tvalid. in_tready
//   rises again in that same cycle, so no new generate beat is taken
//   until the last result is in the output register.
// - A reseed loads the register and runs 6528 warm-up steps, one per
//   cycle, while in_tready stays low.
// - Reset loads both halves with fallback_seed's reset value 1 and runs
//   the same warm-up before in_tready first rises.
// - The result waits in the output register while out_tready is low;
//   a new input beat may be accepted meanwhile, but the next result
//   stalls the block until the register is free.
module lfsr128_scrambled_rng_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [63:0]                         in_tdata,  // [63:0] seed
  input  logic                                in_tuser,  // [0] cmd
  // Result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [63:0]                         out_tdata, // [63:0] random_value
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lfsr128_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                         cfg_data
);
  import lfsr128_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WARM = 3'd1;
  localparam logic [2:0] ST_GEN = 3'd2;
  localparam logic [2:0] ST_MUL = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  word_t            upper_r, upper_nxt;
  word_t            lower_r, lower_nxt;
  word_t            word_r, word_nxt;
  logic             narrow_r;
  word_t            fallback_r;
  logic             out_valid_r, out_valid_nxt;
  word_t            out_data_r, out_data_nxt;
  logic             mul_start;
  logic             mul_done;
  word_t            mul_product;
  logic             feedback;
  word_t            seed_low;
  word_t            load_value;
  logic             in_beat;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_beat = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      narrow_r <= 1'b0;
      fallback_r <= FALLBACK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NARROW_MODE: narrow_r <= cfg_data[0];
        CFG_FALLBACK_SEED: fallback_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero seed falls back to the full 64-bit fallback value, never replicated.
  assign seed_low = {{HALF_W{1'b0}}, in_tdata[HALF_W-1:0]};
  always_comb begin
    if (narrow_r) begin
      load_value = (seed_low == '0) ? fallback_r
                                    : {in_tdata[HALF_W-1:0], in_tdata[HALF_W-1:0]};
    end else begin
      load_value = (in_tdata == '0) ? fallback_r : in_tdata;
    end
  end

  assign feedback = lower_r[0] ^ lower_r[1] ^ lower_r[2] ^ lower_r[7];

  lfsr128_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .operand (word_r),
    .done    (mul_done),
    .product (mul_product)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    upper_nxt = upper_r;
    lower_nxt = lower_r;
    word_nxt = word_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    mul_start = 1'b0;
    unique case (state_r) inside
      ST_IDLE: begin
        if (in_beat) begin
          if (in_tuser == CMD_RESEED) begin
            upper_nxt = load_value;
            lower_nxt = load_value;
            cnt_nxt = WARMUP_STEPS;
            state_nxt = ST_WARM;
          end else begin
            word_nxt = '0;
            cnt_nxt = narrow_r ? BITS_NARROW : BITS_WIDE;
            state_nxt = ST_GEN;
          end
        end
      end
      ST_WARM, ST_GEN: begin
        if (cnt_r == '0) begin
          mul_start = (state_r == ST_GEN);
          state_nxt = (state_r == ST_GEN) ? ST_MUL : ST_IDLE;
        end else begin
          lower_nxt = {upper_r[0], lower_r[WORD_W-1:1]};
          upper_nxt = {feedback, upper_r[WORD_W-1:1]};
          // The bit landing at position 0 after the shift is lower bit 1 now.
          word_nxt = {word_r[WORD_W-2:0], lower_r[1]};
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = narrow_r ? {{HALF_W{1'b0}}, mul_product[HALF_W-1:0]}
                                  : mul_product;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WARM;
      cnt_r <= WARMUP_STEPS;
      upper_r <= FALLBACK_RESET;
      lower_r <= FALLBACK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      upper_r <= upper_nxt;
      lower_r <= lower_nxt;
      out_valid_r <= out_valid_nxt;
    end
    word_r <= word_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  a_reseed_warms: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_tuser == CMD_RESEED |=> state_r == ST_WARM && cnt_r == WARMUP_STEPS)
    else $error("reseed beat did not start the warm-up");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ST_MUL)
    else $error("multiplier finished outside the multiply state");

  a_result_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == ST_HOLD)
    else $error("output beat appeared without a finished product");

  a_gen_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_GEN && cnt_r == '0 |=> state_r == ST_MUL)
    else $error("bit collection did not hand over to the multiplier");

endmodule
